// ===== rtl/bitmap_page_allocator_top_defines.svh =====
// assertion macros for the bitmap page allocator
// no dependencies
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BPA_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define BPA_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

// ===== rtl/bpa_pkg.sv =====
// shared types and constants for the bitmap page allocator
// no dependencies
package bpa_pkg;
    localparam int MaxPages = 4096;
    localparam int WordBits = 32;
    localparam int NumWords = MaxPages / WordBits;
    localparam int AddrW = $clog2(NumWords);
    localparam int BitW = $clog2(WordBits);
    localparam int PageW = $clog2(MaxPages);
    localparam int CntW = 13;

    localparam logic [1:0] FuncAlloc   = 2'd0;
    localparam logic [1:0] FuncFree    = 2'd1;
    localparam logic [1:0] FuncReserve = 2'd2;
    localparam logic [1:0] FuncRelease = 2'd3;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StOom     = 2'd1;
    localparam logic [1:0] StInvalid = 2'd2;
    localparam logic [1:0] StDouble  = 2'd3;

    localparam logic [0:0] CfgNumPages = 1'b0;
    localparam logic [0:0] CfgBasePage = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture request
        logic init_step;  // fill one bitmap word with ones after reset
        logic mem_rd;     // read the word holding the current page
        logic mem_wr;     // write the current word back
        logic scan_step;  // alloc scan one page
        logic walk_step;  // range op one page
        logic fill_init;  // start fill of found run
        logic cnt_add;
        logic cnt_sub;
        logic out_load;
        logic [1:0] out_status;
        logic out_page_sel;
    } bpa_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] func;
        logic zero_cnt;
        logic range_bad;
        logic below_base;
        logic scan_found;
        logic scan_past;
        logic scan_last;
        logic word_end;
        logic init_last;
        logic walk_last;
        logic walk_hit_free;
    } bpa_stat_t;
endpackage

// ===== rtl/bitmap_page_allocator_top.sv =====
// top level of the bitmap page allocator: controller plus datapath
// depends on bpa_pkg, bpa_ctrl, bpa_datapath and the defines header
//
// usage:
//   input channel s_valid/s_ready carries s_func, s_start_page, s_count.
//   result channel m_valid/m_ready carries m_status, m_page, m_used_pages.
//   config writes through cfg_we/cfg_index/cfg_data while idle:
//   index 0 num_pages, index 1 base_page.
//   one word in, one result word out. a rejected request goes from the
//   check straight to the result; a range op reads each bitmap word that it
//   touches, walks its pages and writes the word back; an allocate scans
//   from page 0 for a free run of count pages, then fills it as a range op.
//   the bitmap is a 128 x 32 memory walked one page per cycle, apart from
//   the read of each word before its pages are walked.
//   one request is worked at a time; the next is taken the cycle after the
//   result is handed over.
//   reset clears the counter and loads num_pages=4096, base_page=256, then a
//   pass over all 128 words marks every page used while s_ready stays low.
//   a stalled receiver holds the result in the output register and no new
//   word is taken until it is read.
`include "bitmap_page_allocator_top_defines.svh"
module bitmap_page_allocator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [bpa_pkg::CntW-1:0]    cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [bpa_pkg::PageW-1:0]   s_start_page,
    input  logic [bpa_pkg::CntW-1:0]    s_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [bpa_pkg::PageW-1:0]   m_page,
    output logic [bpa_pkg::CntW-1:0]    m_used_pages
);
    bpa_pkg::bpa_cmd_t  cmd;
    bpa_pkg::bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    bpa_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_func(s_func), .in_start(s_start_page), .in_count(s_count),
        .cmd(cmd), .stat(stat),
        .out_status(m_status), .out_page(m_page), .out_used(m_used_pages)
    );

    `BPA_ASSERT_IMP(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    `BPA_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status))
    `BPA_ASSERT_IMP(a_page_zero, aclk, aresetn, m_valid && m_status != bpa_pkg::StOk, m_page == '0)
endmodule

// ===== rtl/bpa_datapath.sv =====
// datapath: page bitmap, request registers, scan/walk pointers, counter
// depends on bpa_pkg
module bpa_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_idx,
    input  logic [bpa_pkg::CntW-1:0]       cfg_data,
    input  logic [1:0]                     in_func,
    input  logic [bpa_pkg::PageW-1:0]      in_start,
    input  logic [bpa_pkg::CntW-1:0]       in_count,
    input  bpa_pkg::bpa_cmd_t              cmd,
    output bpa_pkg::bpa_stat_t             stat,
    output logic [1:0]                     out_status,
    output logic [bpa_pkg::PageW-1:0]      out_page,
    output logic [bpa_pkg::CntW-1:0]       out_used
);
    localparam int PW = bpa_pkg::PageW;
    localparam int CW = bpa_pkg::CntW;
    localparam int BW = bpa_pkg::BitW;

    // bitmap held as a word memory, 1 = used; the current word sits in word_reg
    logic [bpa_pkg::WordBits-1:0] map_mem [bpa_pkg::NumWords];
    logic [bpa_pkg::WordBits-1:0] word_reg;
    logic [bpa_pkg::WordBits-1:0] word_mod;
    logic [bpa_pkg::WordBits-1:0] mem_wdata;
    logic [CW-1:0] num_pages_reg, base_reg, used_reg;
    logic [1:0] func_reg;
    logic [PW-1:0] start_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;   // scan position or walk position
    logic [CW-1:0] run_reg;   // free run length
    logic [PW-1:0] first_reg;
    logic [CW-1:0] eff_pages;
    logic [CW:0] end_sum;
    logic cur_used;
    logic walk_val;
    logic [PW-1:0] ptr_idx;
    logic [bpa_pkg::AddrW-1:0] word_idx;
    logic [BW-1:0] bit_idx;
    logic [CW:0] add_s;

    assign eff_pages = (num_pages_reg > CW'(bpa_pkg::MaxPages)) ?
                       CW'(bpa_pkg::MaxPages) : num_pages_reg;
    assign end_sum = {2'b0, start_reg} + {1'b0, count_reg};
    assign ptr_idx = ptr_reg[PW-1:0];
    assign word_idx = ptr_reg[PW-1:BW];
    assign bit_idx = ptr_reg[BW-1:0];
    assign cur_used = word_reg[bit_idx];
    assign walk_val = (func_reg == bpa_pkg::FuncReserve);

    assign stat.func = func_reg;
    assign stat.zero_cnt = (count_reg == '0);
    assign stat.range_bad = (end_sum > {1'b0, eff_pages});
    assign stat.below_base = ({1'b0, start_reg} < base_reg);
    assign stat.scan_found = !cur_used && (run_reg + CW'(1) == count_reg);
    assign stat.scan_past = (ptr_reg >= eff_pages);
    assign stat.scan_last = (ptr_reg + CW'(1) >= eff_pages);
    assign stat.word_end = (bit_idx == '1);
    assign stat.init_last = (word_idx == '1);
    assign stat.walk_last = (ptr_reg + CW'(1) == end_sum[CW-1:0]);
    assign stat.walk_hit_free = !cur_used;

    assign add_s = {1'b0, used_reg} + {1'b0, count_reg};

    always_comb begin
        word_mod = word_reg;
        if (cmd.walk_step) word_mod[bit_idx] = walk_val;
    end
    assign mem_wdata = cmd.init_step ? '1 : word_mod;

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr || cmd.init_step) map_mem[word_idx] <= mem_wdata;
        if (cmd.mem_rd) word_reg <= map_mem[word_idx];
        else word_reg <= word_mod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            ptr_reg <= '0;
            num_pages_reg <= CW'(4096);
            base_reg <= CW'(256);
        end else begin
            if (cfg_we) begin
                if (cfg_idx == bpa_pkg::CfgNumPages) num_pages_reg <= cfg_data;
                else base_reg <= {1'b0, cfg_data[PW-1:0]};
            end
            if (cmd.init_step) ptr_reg <= ptr_reg + CW'(bpa_pkg::WordBits);
            if (cmd.load) begin
                func_reg <= in_func;
                start_reg <= in_start;
                count_reg <= in_count;
                ptr_reg <= (in_func == bpa_pkg::FuncAlloc) ? '0 : {1'b0, in_start};
                run_reg <= '0;
            end
            if (cmd.scan_step) begin
                if (!cur_used) begin
                    if (run_reg == '0) first_reg <= ptr_idx;
                    run_reg <= run_reg + CW'(1);
                end else begin
                    run_reg <= '0;
                end
                ptr_reg <= ptr_reg + CW'(1);
            end
            if (cmd.fill_init) begin
                ptr_reg <= (run_reg == '0) ? {1'b0, ptr_idx} : {1'b0, first_reg};
                start_reg <= (run_reg == '0) ? ptr_idx : first_reg;
                first_reg <= (run_reg == '0) ? ptr_idx : first_reg;
                func_reg <= bpa_pkg::FuncReserve;
            end
            if (cmd.walk_step) ptr_reg <= ptr_reg + CW'(1);
            if (cmd.cnt_add) used_reg <= add_s[CW] ? '1 : add_s[CW-1:0];
            if (cmd.cnt_sub) used_reg <= (count_reg > used_reg) ? '0 : used_reg - count_reg;
            if (cmd.out_load) begin
                out_status <= cmd.out_status;
                out_page <= cmd.out_page_sel ? first_reg : '0;
            end
        end
    end
    assign out_used = used_reg;
endmodule

// ===== rtl/bpa_ctrl.sv =====
// controller state machine for the bitmap page allocator
// depends on bpa_pkg
module bpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  bpa_pkg::bpa_stat_t stat,
    output bpa_pkg::bpa_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_CHECK, S_SFETCH, S_SCAN, S_WFETCH, S_WALK, S_OUT
    } state_t;
    state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic is_alloc_fill_reg, is_alloc_fill_next;

    // no new word while the previous result waits in the output register
    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg;
        is_alloc_fill_next = is_alloc_fill_reg;
        cmd = '0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (stat.init_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                is_alloc_fill_next = 1'b0;
                if (stat.func == bpa_pkg::FuncAlloc) begin
                    if (stat.zero_cnt) begin
                        cmd.out_load = 1'b1;
                        cmd.out_status = bpa_pkg::StOom;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_SFETCH;
                    end
                end else if (stat.zero_cnt || stat.range_bad ||
                             (stat.func == bpa_pkg::FuncFree && stat.below_base)) begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = bpa_pkg::StInvalid;
                    state_next = S_OUT;
                end else begin
                    state_next = S_WFETCH;
                end
            end
            S_SFETCH: begin
                cmd.mem_rd = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.scan_past) begin
                    // empty page range
                    cmd.out_load = 1'b1;
                    cmd.out_status = bpa_pkg::StOom;
                    state_next = S_OUT;
                end else if (stat.scan_found) begin
                    cmd.fill_init = 1'b1;
                    is_alloc_fill_next = 1'b1;
                    state_next = S_WFETCH;
                end else if (stat.scan_last) begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = bpa_pkg::StOom;
                    state_next = S_OUT;
                end else begin
                    cmd.scan_step = 1'b1;
                    if (stat.word_end) state_next = S_SFETCH;
                end
            end
            S_WFETCH: begin
                cmd.mem_rd = 1'b1;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (stat.func == bpa_pkg::FuncFree && stat.walk_hit_free) begin
                    // keep the pages already cleared in this word
                    cmd.mem_wr = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_status = bpa_pkg::StDouble;
                    state_next = S_OUT;
                end else begin
                    cmd.walk_step = 1'b1;
                    if (stat.walk_last) begin
                        cmd.mem_wr = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_status = bpa_pkg::StOk;
                        cmd.out_page_sel = is_alloc_fill_reg;
                        cmd.cnt_add = (stat.func == bpa_pkg::FuncReserve);
                        cmd.cnt_sub = (stat.func == bpa_pkg::FuncFree);
                        state_next = S_OUT;
                    end else if (stat.word_end) begin
                        cmd.mem_wr = 1'b1;
                        state_next = S_WFETCH;
                    end
                end
            end
            S_OUT: begin
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            m_valid_reg <= 1'b0;
            is_alloc_fill_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            is_alloc_fill_reg <= is_alloc_fill_next;
        end
    end
endmodule
